// ===== sv/aes_ke_pkg.sv =====
// Shared types, constants and the S-box for the AES key schedule expander.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package aes_ke_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned NK_W    = 4;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned MAX_NK  = 8;

  // Key length codes as written to the configuration register
  localparam logic [NK_W-1:0] KEY_WORDS_128 = 4'd4;
  localparam logic [NK_W-1:0] KEY_WORDS_192 = 4'd6;
  localparam logic [NK_W-1:0] KEY_WORDS_256 = 4'd8;

  // Index of the last schedule word for each key length
  localparam logic [INDEX_W-1:0] LAST_IDX_128 = 6'd43;
  localparam logic [INDEX_W-1:0] LAST_IDX_192 = 6'd51;
  localparam logic [INDEX_W-1:0] LAST_IDX_256 = 6'd59;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] RCON_POLY  = 8'h1b;

  typedef struct packed {
    logic [63:0] key_part0;
    logic [63:0] key_part1;
    logic [63:0] key_part2;
    logic [63:0] key_part3;
  } key_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] word_index;
    logic [WORD_W-1:0]  round_key_word;
    logic               last_word;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic               load;
    logic               step;
    logic               key_phase;
    logic               rot_sub;
    logic               sub_only;
    logic [NK_W-1:0]    nk;
    logic [INDEX_W-1:0] idx;
    logic               last;
  } dp_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/aes_ke_ctrl.sv =====
// Sequencer for the AES key schedule expander: key length register, word
// counter and command generation. Depends on aes_ke_pkg.
`default_nettype none

module aes_ke_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [aes_ke_pkg::NK_W-1:0]   cfg_data_i,
  output aes_ke_pkg::dp_cmd_t           cmd_o,
  output logic                          result_valid_o
);
  import aes_ke_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic               state_q, state_d;
  logic [NK_W-1:0]    cfg_nk_q;
  logic [NK_W-1:0]    nk_q, nk_d;
  logic [INDEX_W-1:0] idx_q, idx_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               valid_q;
  logic [NK_W-1:0]    nk_decoded;
  logic [INDEX_W-1:0] last_idx;
  logic [POS_W-1:0]   pos_wrap;
  logic               key_phase;
  logic               accept;
  logic               last;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = (state_q == ST_RUN);
  assign accept      = start_i && (state_q == ST_IDLE);

  always_comb begin
    unique case (cfg_nk_q)
      KEY_WORDS_128: nk_decoded = KEY_WORDS_128;
      KEY_WORDS_192: nk_decoded = KEY_WORDS_192;
      default:       nk_decoded = KEY_WORDS_256;
    endcase
  end

  always_comb begin
    unique case (nk_q)
      KEY_WORDS_128: last_idx = LAST_IDX_128;
      KEY_WORDS_192: last_idx = LAST_IDX_192;
      default:       last_idx = LAST_IDX_256;
    endcase
  end

  assign pos_wrap  = POS_W'(nk_q - 4'd1);
  assign key_phase = ({2'b00, nk_q} > idx_q);
  assign last      = (idx_q == last_idx);

  always_comb begin
    state_d = state_q;
    nk_d    = nk_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RUN;
          nk_d    = nk_decoded;
          idx_d   = '0;
          pos_d   = '0;
        end
      end
      default: begin
        idx_d = idx_q + 6'd1;
        pos_d = (pos_q == pos_wrap) ? '0 : pos_q + 3'd1;
        if (last) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cmd_o.load      = accept;
    cmd_o.step      = (state_q == ST_RUN);
    cmd_o.key_phase = key_phase;
    cmd_o.rot_sub   = !key_phase && (pos_q == '0);
    cmd_o.sub_only  = !key_phase && (nk_q == KEY_WORDS_256) && (pos_q == 3'd4);
    cmd_o.nk        = nk_q;
    cmd_o.idx       = idx_q;
    cmd_o.last      = last;
  end

  assign result_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cfg_nk_q <= KEY_WORDS_256;
      nk_q     <= KEY_WORDS_256;
      idx_q    <= '0;
      pos_q    <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      nk_q    <= nk_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      valid_q <= (state_q == ST_RUN);
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_nk_q <= cfg_data_i;
      end
    end
  end

  a_nk_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nk_q == KEY_WORDS_128) || (nk_q == KEY_WORDS_192) || (nk_q == KEY_WORDS_256))
    else $error("latched key length is not 4, 6 or 8");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (idx_q <= last_idx))
    else $error("word index ran past the end of the schedule");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && last) |=> (state_q == ST_IDLE))
    else $error("run did not end after the last word");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (pos_q <= pos_wrap))
    else $error("column position out of range");

  a_strobe_follows_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q == ST_RUN))
    else $error("result strobe without a schedule step");

endmodule

`default_nettype wire

// ===== sv/aes_ke_datapath.sv =====
// Datapath of the AES key schedule expander: key word queue, history window
// of the last eight words, S-box transform, round constant and result register.
// Depends on aes_ke_pkg.
`default_nettype none

module aes_ke_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  aes_ke_pkg::key_item_t key_i,
  input  aes_ke_pkg::dp_cmd_t   cmd_i,
  output aes_ke_pkg::result_t   result_o
);
  import aes_ke_pkg::*;

  logic [WORD_W-1:0] key_q [MAX_NK];
  logic [WORD_W-1:0] hist_q [MAX_NK];
  logic [7:0]        rcon_q, rcon_d;
  result_t           result_q;
  logic [WORD_W-1:0] prev_word;
  logic [WORD_W-1:0] back_word;
  logic [WORD_W-1:0] sub_in;
  logic [WORD_W-1:0] sub_out;
  logic [WORD_W-1:0] temp;
  logic [WORD_W-1:0] new_word;

  assign prev_word = hist_q[0];

  // Word nk back in the history window
  always_comb begin
    unique case (cmd_i.nk)
      KEY_WORDS_128: back_word = hist_q[3];
      KEY_WORDS_192: back_word = hist_q[5];
      default:       back_word = hist_q[7];
    endcase
  end

  assign sub_in  = cmd_i.rot_sub ? {prev_word[23:0], prev_word[31:24]} : prev_word;
  assign sub_out = sub_word(sub_in);

  always_comb begin
    priority if (cmd_i.rot_sub) begin
      temp = sub_out ^ {rcon_q, 24'h000000};
    end else if (cmd_i.sub_only) begin
      temp = sub_out;
    end else begin
      temp = prev_word;
    end
  end

  assign new_word = cmd_i.key_phase ? key_q[0] : (back_word ^ temp);

  always_comb begin
    rcon_d = rcon_q;
    if (cmd_i.load) begin
      rcon_d = RCON_FIRST;
    end else if (cmd_i.step && cmd_i.rot_sub) begin
      rcon_d = {rcon_q[6:0], 1'b0} ^ (rcon_q[7] ? RCON_POLY : 8'h00);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcon_q <= RCON_FIRST;
    end else begin
      rcon_q <= rcon_d;
    end
  end

  // Payload registers: key queue, history window, result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q[0] <= key_i.key_part0[63:32];
      key_q[1] <= key_i.key_part0[31:0];
      key_q[2] <= key_i.key_part1[63:32];
      key_q[3] <= key_i.key_part1[31:0];
      key_q[4] <= key_i.key_part2[63:32];
      key_q[5] <= key_i.key_part2[31:0];
      key_q[6] <= key_i.key_part3[63:32];
      key_q[7] <= key_i.key_part3[31:0];
    end else if (cmd_i.step) begin
      for (int k = 0; k < MAX_NK - 1; k++) begin
        key_q[k] <= key_q[k+1];
      end
    end
    if (cmd_i.step) begin
      hist_q[0] <= new_word;
      for (int k = 1; k < MAX_NK; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
      result_q.word_index     <= cmd_i.idx;
      result_q.round_key_word <= new_word;
      result_q.last_word      <= cmd_i.last;
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== sv/aes_key_expansion_core.sv =====
// Top level of the AES key schedule expander: joins the sequencer and the
// datapath. Depends on aes_ke_pkg, aes_ke_ctrl and aes_ke_datapath.
//
// Usage:
//   Write the key length (4, 6 or 8 words; anything else means 8) on the
//   cfg_valid_i/cfg_ready_o channel while the block is idle; cfg_ready_o is
//   always high. Reset leaves the length at 8 words.
//   Present a key on key_i with start high; the beat is taken when busy is
//   low. The block then emits the expanded schedule, one word per cycle:
//   44, 52 or 60 words, each marked by a single-cycle result_valid_o strobe,
//   with its index and a flag on the final word.
//   The start beat moves the sequencer to run; each step registers a word
//   into result_o. The schedule is generated serially by one S-box unit
//   over a sliding window of the last eight words, so no new key is taken
//   until the run ends; busy falls in the cycle that shows the last word.
//   The receiver cannot stall: every strobed word must be taken.
//   Reset returns the sequencer to idle and drops any schedule in progress.
`default_nettype none

module aes_key_expansion_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  aes_ke_pkg::key_item_t       key_i,
  output logic                        result_valid_o,
  output aes_ke_pkg::result_t         result_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [aes_ke_pkg::NK_W-1:0] cfg_data_i
);
  import aes_ke_pkg::*;

  dp_cmd_t cmd;

  aes_ke_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .cmd_o          (cmd),
    .result_valid_o (result_valid_o)
  );

  aes_ke_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_i    (key_i),
    .cmd_i    (cmd),
    .result_o (result_o)
  );

endmodule

`default_nettype wire
